FILE: sv/assert_macros.svh
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deframer assertion failed");
`define DPD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `DPD_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define DPD_ASSERT(lbl, clk, rst_n, prop)
`define DPD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: sv/dpd_pkg.sv
// Types and constants of the debug packet deframer.
package dpd_pkg;

  localparam int unsigned DATA_W      = 7;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned CMD_DEPTH   = 4;

  localparam logic [LEN_W-1:0] MAX_BODY_RESET = 16'd1024;

  localparam logic [DATA_W-1:0] CH_DOLLAR = 7'h24;
  localparam logic [DATA_W-1:0] CH_HASH   = 7'h23;
  localparam logic [DATA_W-1:0] CH_COLON  = 7'h3a;
  localparam logic [DATA_W-1:0] CH_PLUS   = 7'h2b;
  localparam logic [DATA_W-1:0] CH_MINUS  = 7'h2d;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_TX      = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] data;
    status_e           status;
    logic [LEN_W-1:0]  len;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]           count;
    res_t [MAX_RESULTS-1:0]     res;
  } cmd_t;

endpackage

FILE: sv/debug_packet_deframer.sv
// Debug packet deframer: $body#hh receiver with checksum check and sequence-id echo.
// A byte's first result reaches the result ports through the command queue, then
// the output register. Throughput: one byte per cycle unless full_o is high; the
// sequencer delivers one result per cycle unless the output is held, up to four
// per byte, so bursts of multi-result bytes are absorbed by the CmdDepth queue.
// Reset: framing returns to hunting for '$', queues empty, max_body_length = 1024.
module debug_packet_deframer #(
  parameter int unsigned CmdDepth = dpd_pkg::CMD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] max_body_length_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [1:0]  kind_o,
  output logic [6:0]  data_o,
  output logic [1:0]  status_o,
  output logic [15:0] payload_length_o,
  output logic        last_o
);

  `include "assert_macros.svh"

  logic          accept;
  logic          cmd_push;
  dpd_pkg::cmd_t cmd_w;
  dpd_pkg::cmd_t cmd_r;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          out_valid;
  dpd_pkg::res_t out_res;
  logic          out_last;

  assign cfg_ready_o = 1'b1;
  assign full_o      = cmd_full;
  assign accept      = push_i && !cmd_full;

  dpd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .max_body_length_i(max_body_length_i),
    .accept_i         (accept),
    .rx_byte_i        (rx_byte_i),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_w)
  );

  dpd_cmd_fifo #(
    .Depth(CmdDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_w),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .rdata_o(cmd_r)
  );

  dpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_r),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid),
    .out_pop_i  (pop_i),
    .out_res_o  (out_res),
    .out_last_o (out_last)
  );

  assign empty_o          = !out_valid;
  assign kind_o           = out_res.kind;
  assign data_o           = out_res.data;
  assign status_o         = out_res.status;
  assign payload_length_o = out_res.len;
  assign last_o           = out_last;

  `DPD_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, cmd_push && cmd_full)
  `DPD_ASSERT(a_cmd_count_range, clk_i, rst_ni,
              cmd_push |-> (cmd_w.count != 3'd0 && cmd_w.count <= 3'd4))
  `DPD_ASSERT(a_verdict_is_last, clk_i, rst_ni,
              (out_valid && out_res.kind == dpd_pkg::KIND_VERDICT) |->
              (out_last && out_res.data == '0))
  `DPD_ASSERT(a_pop_needs_cmd, clk_i, rst_ni, cmd_pop |-> !cmd_empty)

endmodule

FILE: sv/dpd_front.sv
// Front end: frames bytes, tracks checksum, emits at most one result command per byte.
module dpd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [dpd_pkg::LEN_W-1:0]     max_body_length_i,
  input  logic                          accept_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          cmd_push_o,
  output dpd_pkg::cmd_t                 cmd_o
);

  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_BODY  = 4'b0010,
    PH_SUMHI = 4'b0100,
    PH_SUMLO = 4'b1000
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [7:0]                      sum_q, sum_d;
  logic [dpd_pkg::LEN_W-1:0]       cnt_q, cnt_d;
  logic                            seq_q, seq_d;
  logic [7:0]                      hi_q, hi_d;
  logic [dpd_pkg::LEN_W-1:0]       max_q;
  logic [dpd_pkg::DATA_W-1:0]      held_q [3];
  logic                            held_we;
  logic [1:0]                      held_idx;
  logic [dpd_pkg::DATA_W-1:0]      ch;
  logic [4:0]                      dig;
  logic [7:0]                      sent;
  logic [dpd_pkg::LEN_W-1:0]       dlen;
  dpd_pkg::cmd_t                   cmd;

  // bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [dpd_pkg::DATA_W-1:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 7'h61 && c <= 7'h66) begin
      r = {1'b0, 4'(c - 7'h57)};
    end else if (c >= 7'h30 && c <= 7'h39) begin
      r = {1'b0, 4'(c - 7'h30)};
    end else if (c >= 7'h41 && c <= 7'h46) begin
      r = {1'b0, 4'(c - 7'h37)};
    end
    return r;
  endfunction

  function automatic dpd_pkg::res_t mk(input dpd_pkg::kind_e k,
                                       input logic [dpd_pkg::DATA_W-1:0] d,
                                       input dpd_pkg::status_e s,
                                       input logic [dpd_pkg::LEN_W-1:0] l);
    dpd_pkg::res_t r;
    r.kind   = k;
    r.data   = d;
    r.status = s;
    r.len    = l;
    return r;
  endfunction

  always_comb begin
    ch       = rx_byte_i[6:0];
    dig      = hex_digit(ch);
    phase_d  = phase_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    seq_d    = seq_q;
    hi_d     = hi_q;
    held_we  = 1'b0;
    held_idx = cnt_q[1:0];
    cmd      = '0;
    sent     = hi_q + (dig[4] ? 8'hff : {4'h0, dig[3:0]});
    dlen     = (seq_q && cnt_q >= 16'd3) ? cnt_q - 16'd3 : cnt_q;
    case (phase_q)
      PH_HUNT: begin
        if (ch == dpd_pkg::CH_DOLLAR) begin
          sum_d = '0;
          cnt_d = '0;
          seq_d = 1'b0;
          hi_d  = '0;
          if (max_q == '0) begin
            cmd.res[0] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_OVERFLOW, '0);
            cmd.count  = 3'd1;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (ch == dpd_pkg::CH_HASH) begin
          phase_d = PH_SUMHI;
          if (cnt_q == 16'd1) begin
            cmd.res[0] = mk(dpd_pkg::KIND_PAYLOAD, held_q[0], dpd_pkg::ST_GOOD, '0);
            cmd.count  = 3'd1;
          end else if (cnt_q == 16'd2) begin
            cmd.res[0] = mk(dpd_pkg::KIND_PAYLOAD, held_q[0], dpd_pkg::ST_GOOD, '0);
            cmd.res[1] = mk(dpd_pkg::KIND_PAYLOAD, held_q[1], dpd_pkg::ST_GOOD, '0);
            cmd.count  = 3'd2;
          end
        end else begin
          sum_d = sum_q + {1'b0, ch};
          if (cnt_q < 16'd2) begin
            held_we = 1'b1;
            cnt_d   = cnt_q + 16'd1;
            if (cnt_d >= max_q) begin
              phase_d = PH_HUNT;
              if (cnt_q == '0) begin
                cmd.res[0] = mk(dpd_pkg::KIND_PAYLOAD, ch, dpd_pkg::ST_GOOD, '0);
                cmd.res[1] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_OVERFLOW, 16'd1);
                cmd.count  = 3'd2;
              end else begin
                cmd.res[0] = mk(dpd_pkg::KIND_PAYLOAD, held_q[0], dpd_pkg::ST_GOOD, '0);
                cmd.res[1] = mk(dpd_pkg::KIND_PAYLOAD, ch, dpd_pkg::ST_GOOD, '0);
                cmd.res[2] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_OVERFLOW, 16'd2);
                cmd.count  = 3'd3;
              end
            end
          end else if (cnt_q == 16'd2) begin
            held_we = 1'b1;
            cnt_d   = 16'd3;
            if (ch == dpd_pkg::CH_COLON) begin
              seq_d = 1'b1;
              if (16'd3 >= max_q) begin
                phase_d    = PH_HUNT;
                cmd.res[0] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_OVERFLOW, '0);
                cmd.count  = 3'd1;
              end
            end else begin
              cmd.res[0] = mk(dpd_pkg::KIND_PAYLOAD, held_q[0], dpd_pkg::ST_GOOD, '0);
              cmd.res[1] = mk(dpd_pkg::KIND_PAYLOAD, held_q[1], dpd_pkg::ST_GOOD, '0);
              cmd.res[2] = mk(dpd_pkg::KIND_PAYLOAD, ch, dpd_pkg::ST_GOOD, '0);
              cmd.count  = 3'd3;
              if (16'd3 >= max_q) begin
                phase_d    = PH_HUNT;
                cmd.res[3] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_OVERFLOW, 16'd3);
                cmd.count  = 3'd4;
              end
            end
          end else begin
            cnt_d      = (cnt_q != 16'hffff) ? cnt_q + 16'd1 : cnt_q;
            cmd.res[0] = mk(dpd_pkg::KIND_PAYLOAD, ch, dpd_pkg::ST_GOOD, '0);
            cmd.count  = 3'd1;
            if (cnt_d >= max_q) begin
              phase_d    = PH_HUNT;
              cmd.res[1] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_OVERFLOW,
                              seq_q ? cnt_d - 16'd3 : cnt_d);
              cmd.count  = 3'd2;
            end
          end
        end
      end
      PH_SUMHI: begin
        hi_d    = dig[4] ? 8'hf0 : {dig[3:0], 4'h0};
        phase_d = PH_SUMLO;
      end
      PH_SUMLO: begin
        phase_d = PH_HUNT;
        if (sent != sum_q) begin
          cmd.res[0] = mk(dpd_pkg::KIND_TX, dpd_pkg::CH_MINUS, dpd_pkg::ST_GOOD, '0);
          cmd.res[1] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_MISMATCH, dlen);
          cmd.count  = 3'd2;
        end else if (seq_q) begin
          cmd.res[0] = mk(dpd_pkg::KIND_TX, dpd_pkg::CH_PLUS, dpd_pkg::ST_GOOD, '0);
          cmd.res[1] = mk(dpd_pkg::KIND_TX, held_q[0], dpd_pkg::ST_GOOD, '0);
          cmd.res[2] = mk(dpd_pkg::KIND_TX, held_q[1], dpd_pkg::ST_GOOD, '0);
          cmd.res[3] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_GOOD, dlen);
          cmd.count  = 3'd4;
        end else begin
          cmd.res[0] = mk(dpd_pkg::KIND_TX, dpd_pkg::CH_PLUS, dpd_pkg::ST_GOOD, '0);
          cmd.res[1] = mk(dpd_pkg::KIND_VERDICT, '0, dpd_pkg::ST_GOOD, dlen);
          cmd.count  = 3'd2;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  assign cmd_push_o = accept_i && (cmd.count != '0);
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sum_q   <= '0;
      cnt_q   <= '0;
      seq_q   <= 1'b0;
      hi_q    <= '0;
      max_q   <= dpd_pkg::MAX_BODY_RESET;
    end else begin
      if (cfg_valid_i) begin
        max_q <= max_body_length_i;
      end
      if (accept_i) begin
        phase_q <= phase_d;
        sum_q   <= sum_d;
        cnt_q   <= cnt_d;
        seq_q   <= seq_d;
        hi_q    <= hi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && held_we) begin
      held_q[held_idx] <= ch;
    end
  end

endmodule

FILE: sv/dpd_cmd_fifo.sv
// Short command queue between the front end and the result sequencer.
module dpd_cmd_fifo #(
  parameter int unsigned Depth = dpd_pkg::CMD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dpd_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dpd_pkg::cmd_t rdata_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  dpd_pkg::cmd_t    mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/dpd_back.sv
// Back end: unrolls queued commands into single results behind an output register.
module dpd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_empty_i,
  input  dpd_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_pop_i,
  output dpd_pkg::res_t              out_res_o,
  output logic                       out_last_o
);

  logic [1:0]    idx_q;
  logic          out_valid_q;
  dpd_pkg::res_t out_res_q;
  logic          out_last_q;
  logic          load;
  logic          is_last;

  assign load      = !cmd_empty_i && (!out_valid_q || out_pop_i);
  assign is_last   = ({1'b0, idx_q} + 3'd1) == cmd_i.count;
  assign cmd_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q  <= cmd_i.res[idx_q];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

endmodule
